/* sv/spq_pkg.sv */
// Shared types and constants for the sorted priority queue.
// Used by the interfaces, the cell and the top level; no dependencies.
`default_nettype none
package spq_pkg;

  localparam int DEPTH   = 8;
  localparam int VALUE_W = 32;
  localparam int RANK_W  = 16;

  typedef logic [1:0] status_t;

  localparam status_t ST_STORED  = 2'd0;
  localparam status_t ST_REMOVED = 2'd1;
  localparam status_t ST_FULL    = 2'd2;
  localparam status_t ST_EMPTY   = 2'd3;

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  typedef struct packed {
    logic                      valid;
    logic signed [VALUE_W-1:0] value;
    logic [RANK_W-1:0]         rank;
  } entry_t;

  // Operation broadcast to every cell in the row.
  typedef struct packed {
    logic                      enq;
    logic                      deq;
    logic signed [VALUE_W-1:0] value;
    logic [RANK_W-1:0]         rank;
  } cmd_t;

endpackage
`default_nettype wire

/* sv/spq_ifs.sv */
// Valid/ready channel interfaces for the request and result transactions.
// Depends on spq_pkg for field widths and types.
`default_nettype none
interface spq_req_if;
  logic                               valid;
  logic                               ready;
  logic                               mode;
  logic signed [spq_pkg::VALUE_W-1:0] value_in;
  logic [spq_pkg::RANK_W-1:0]         rank_in;

  modport source(output valid, mode, value_in, rank_in, input ready);
  modport sink(input valid, mode, value_in, rank_in, output ready);
endinterface

interface spq_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [spq_pkg::VALUE_W-1:0] value_out;
  spq_pkg::status_t                   status;

  modport source(output valid, value_out, status, input ready);
  modport sink(input valid, value_out, status, output ready);
endinterface
`default_nettype wire

/* sv/spq_cell.sv */
// One storage cell of the sorted row: holds an entry, compares its rank with
// the broadcast operation and shifts with its neighbors. Depends on spq_pkg.
`default_nettype none
module spq_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire spq_pkg::cmd_t   cmd,
  input  wire spq_pkg::entry_t prev_entry,
  input  wire logic            prev_greater,
  input  wire spq_pkg::entry_t next_entry,
  output spq_pkg::entry_t      entry,
  output logic                 greater
);

  logic take_new;

  assign greater  = entry.valid && (entry.rank > cmd.rank);
  // First slot that is free or holds a larger rank, right behind a valid cell.
  assign take_new = prev_entry.valid && !prev_greater && (!entry.valid || greater);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (cmd.deq) begin
      entry.valid <= next_entry.valid;
    end else if (cmd.enq && (prev_greater || take_new)) begin
      entry.valid <= 1'b1;
    end

    if (cmd.deq) begin
      entry.value <= next_entry.value;
      entry.rank  <= next_entry.rank;
    end else if (cmd.enq && prev_greater) begin
      entry.value <= prev_entry.value;
      entry.rank  <= prev_entry.rank;
    end else if (cmd.enq && take_new) begin
      entry.value <= cmd.value;
      entry.rank  <= cmd.rank;
    end
  end

endmodule
`default_nettype wire

/* sv/sorted_priority_queue.sv */
// Sorted priority queue: a row of DEPTH cells kept in ascending rank order.
// Response: the result of each accepted request transaction is registered.
// Throughput: one transaction per cycle; every cell compares and shifts in the
// same cycle, and a stalled result register holds off new requests.
// Reset: all cells read empty and the result valid flag is cleared.
// Depends on spq_pkg, spq_ifs and spq_cell.
`default_nettype none
module sorted_priority_queue (
  input  wire logic  clk,
  input  wire logic  rst,
  spq_req_if.sink    req,
  spq_rsp_if.source  rsp
);

  localparam spq_pkg::entry_t HEAD_PREV = '{valid: 1'b1, value: '0, rank: '0};
  localparam spq_pkg::entry_t TAIL_NEXT = '{valid: 1'b0, value: '0, rank: '0};

  spq_pkg::entry_t             cells   [spq_pkg::DEPTH];
  logic [spq_pkg::DEPTH-1:0]   greater;
  logic [spq_pkg::DEPTH-1:0]   valid_vec;
  spq_pkg::cmd_t               cmd;
  logic                        accept;
  logic                        full;
  logic                        empty;

  assign full   = cells[spq_pkg::DEPTH-1].valid;
  assign empty  = !cells[0].valid;
  assign accept = req.valid && req.ready;

  assign req.ready = !rsp.valid || rsp.ready;

  assign cmd.enq   = accept && (req.mode == spq_pkg::MODE_ENQ) && !full;
  assign cmd.deq   = accept && (req.mode == spq_pkg::MODE_DEQ) && !empty;
  assign cmd.value = req.value_in;
  assign cmd.rank  = req.rank_in;

  for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
    spq_pkg::entry_t prev_e;
    spq_pkg::entry_t next_e;
    logic            prev_g;

    if (i == 0) begin : g_head
      assign prev_e = HEAD_PREV;
      assign prev_g = 1'b0;
    end else begin : g_body
      assign prev_e = cells[i-1];
      assign prev_g = greater[i-1];
    end

    if (i == spq_pkg::DEPTH - 1) begin : g_tail
      assign next_e = TAIL_NEXT;
    end else begin : g_mid
      assign next_e = cells[i+1];
    end

    spq_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .cmd          (cmd),
      .prev_entry   (prev_e),
      .prev_greater (prev_g),
      .next_entry   (next_e),
      .entry        (cells[i]),
      .greater      (greater[i])
    );

    assign valid_vec[i] = cells[i].valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (req.mode == spq_pkg::MODE_ENQ) begin
        rsp.value_out <= '0;
        rsp.status    <= full ? spq_pkg::ST_FULL : spq_pkg::ST_STORED;
      end else if (empty) begin
        rsp.value_out <= '0;
        rsp.status    <= spq_pkg::ST_EMPTY;
      end else begin
        rsp.value_out <= cells[0].value;
        rsp.status    <= spq_pkg::ST_REMOVED;
      end
    end
  end

  // Occupied cells always form a prefix of the row.
  a_prefix: assert property (@(posedge clk) disable iff (rst)
    $onehot({1'b0, valid_vec} + {{spq_pkg::DEPTH{1'b0}}, 1'b1}))
    else $error("occupied cells are not contiguous from the head");

  a_deq_count: assert property (@(posedge clk) disable iff (rst)
    cmd.deq |=> $countones(valid_vec) == $past($countones(valid_vec)) - 1)
    else $error("dequeue did not remove exactly one entry");

  a_enq_count: assert property (@(posedge clk) disable iff (rst)
    cmd.enq |=> $countones(valid_vec) == $past($countones(valid_vec)) + 1)
    else $error("enqueue did not add exactly one entry");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    accept && (req.mode == spq_pkg::MODE_ENQ) && full |=>
      rsp.status == spq_pkg::ST_FULL && $stable(valid_vec))
    else $error("rejected enqueue changed the queue");

  for (genvar j = 1; j < spq_pkg::DEPTH; j++) begin : g_order_chk
    a_sorted: assert property (@(posedge clk) disable iff (rst)
      cells[j].valid |-> cells[j-1].rank <= cells[j].rank)
      else $error("cells out of rank order");
  end

endmodule
`default_nettype wire
